>>> src/plsm_pkg.sv
`timescale 1ns / 1ps
// Package for the packet latency statistics monitor: field widths, request structs,
// register indexes, reset values and divider constants. No dependencies.
package plsm_pkg;

    localparam int STAGES_DEF    = 3;

    localparam int TS_W          = 48;
    localparam int BYTES_W       = 32;
    localparam int CNT_W         = 32;
    localparam int TOT_W         = 64;
    localparam int OVR_W         = 32;
    localparam int OSUM_W        = 34;
    localparam int STAGE_W       = 2;
    localparam int INTV_W        = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 48;

    localparam logic [TS_W-1:0]   THR_RESET  = 48'd20;
    localparam logic [INTV_W-1:0] INTV_RESET = 16'd200;

    // shared divider: 64-bit dividend, 32-bit divisor, bits retired per cycle
    localparam int DIV_N_W       = 64;
    localparam int DIV_D_W       = 32;
    localparam int DIV_STEP_BITS = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_THRESHOLD = 1'b0;
    localparam t_cfg_idx CFG_INTERVAL  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TS_W-1:0]   create_time;
        logic [TS_W-1:0]   bridge_recv_time;
        logic [TS_W-1:0]   bridge_send_time;
        logic [TS_W-1:0]   api_recv_time;
        logic [BYTES_W-1:0] packet_bytes;
    } t_in_req;

    typedef struct packed {
        logic               group_id;
        logic [STAGE_W-1:0] stage;
        logic [CNT_W-1:0]   packet_count;
        logic [TOT_W-1:0]   byte_total;
        logic [TOT_W-1:0]   latency_total;
        logic [TS_W-1:0]    latency_average;
        logic [TS_W-1:0]    latency_max;
        logic [TS_W-1:0]    latency_min;
        logic [OVR_W-1:0]   over_count;
        logic [OSUM_W-1:0]  over_sum;
        logic [TS_W-1:0]    current_latency;
        logic               is_last;
    } t_out_req;

    // one entry of the group memory
    typedef struct packed {
        logic [CNT_W-1:0] packets;
        logic [TOT_W-1:0] bytes;
    } t_grp_ent;

    // one entry of the stage memory
    typedef struct packed {
        logic [TOT_W-1:0] total;
        logic [TS_W-1:0]  lmax;
        logic [TS_W-1:0]  lmin;
        logic [OVR_W-1:0] overs;
    } t_stg_ent;

    localparam t_stg_ent STG_ENT_RESET = '{total: '0, lmax: '0, lmin: '1, overs: '0};

    typedef struct packed {
        logic               start;
        logic               short_op;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic               busy;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } t_div_sts;

endpackage

>>> src/plsm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plsm_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 2,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/plsm_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, DIV_STEP_BITS quotient bits per cycle.
// Depends on plsm_pkg. Short mode divides a 32-bit dividend.
module plsm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plsm_pkg::t_div_cmd i_cmd,
    output plsm_pkg::t_div_sts o_sts
);

    localparam int N_W        = plsm_pkg::DIV_N_W;
    localparam int D_W        = plsm_pkg::DIV_D_W;
    localparam int STEP       = plsm_pkg::DIV_STEP_BITS;
    localparam int ITER_LONG  = N_W / STEP;
    localparam int ITER_SHORT = D_W / STEP;
    localparam int LEFT_W     = $clog2(ITER_LONG + 1);

    logic              r_busy;
    logic [LEFT_W-1:0] r_left;
    logic [D_W-1:0]    r_rem;
    logic [N_W-1:0]    r_sh;
    logic [D_W-1:0]    r_div;
    logic [D_W-1:0]    n_rem;
    logic [N_W-1:0]    n_sh;

    always_comb begin
        logic [D_W:0] trial;
        n_rem = r_rem;
        n_sh  = r_sh;
        trial = '0;
        for (int b = 0; b < STEP; b++) begin
            trial = {n_rem, n_sh[N_W-1]};
            n_sh  = {n_sh[N_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial   = trial - {1'b0, r_div};
                n_sh[0] = 1'b1;
            end
            n_rem = trial[D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_left <= i_cmd.short_op ? LEFT_W'(ITER_SHORT) : LEFT_W'(ITER_LONG);
        end else if (r_busy) begin
            r_left <= r_left - LEFT_W'(1);
            if (r_left == LEFT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_div <= i_cmd.divisor;
            r_sh  <= i_cmd.short_op ? {i_cmd.dividend[D_W-1:0], {(N_W-D_W){1'b0}}}
                                    : i_cmd.dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_sts.busy      = r_busy;
    assign o_sts.quotient  = r_sh;
    assign o_sts.remainder = r_rem;

endmodule

>>> src/packet_latency_stats_monitor_core.sv
`timescale 1ns / 1ps
// Top level of the packet latency statistics monitor.
// Depends on plsm_pkg, plsm_ram and plsm_div.

// Each request carries a group select, four ms timestamps and a byte count. The block
// forms STAGES latencies (consecutive timestamp differences, modulo 2^48) and updates
// per-group packet/byte totals and per-stage latency total, max, min and over-threshold
// count, all saturating. Group state lives in a 2-entry RAM, stage state in a
// 2*STAGES-entry RAM, each read issued in the cycle before its write-back; per-entry valid
// flops stand in for the reset values, so there is no clearing pass after reset.
// Flow: a request passes through the group update and one read-modify-write per stage;
// when it can report (interval nonzero, count not saturated), a short-mode remainder
// check on the shared divider follows.
// When the group count reaches a multiple of report_interval, one result request per
// stage follows, each paced by a long-mode average division on the divider, plus
// any time the output side stalls. The next request is taken once the final result of
// a report sits in the output register. Config writes land at any write-enable edge
// and are expected only while the block is idle.
module packet_latency_stats_monitor_core #(
    parameter int STAGES = plsm_pkg::STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input requests
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  plsm_pkg::t_in_req                 i_in,
    // result requests
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output plsm_pkg::t_out_req                o_out,
    // configuration writes
    input  logic                              i_cfg_we,
    input  plsm_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [plsm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int STG_DEPTH = 2 * STAGES;
    localparam int ADDR_W    = $clog2(STG_DEPTH);
    localparam int SIDX_W    = $clog2(STAGES + 1);
    localparam int TS_W      = plsm_pkg::TS_W;
    localparam int CNT_W     = plsm_pkg::CNT_W;
    localparam int TOT_W     = plsm_pkg::TOT_W;
    localparam int OVR_W     = plsm_pkg::OVR_W;
    localparam int OSUM_W    = plsm_pkg::OSUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRP,      // group entry read back, write updated count and bytes
        S_STG,      // one stage entry per cycle: update, write back, read next
        S_MOD,      // count modulo interval on the divider
        S_RPT_RD,   // read stage entry for the report
        S_RPT_DIV,  // latch entry, start the average
        S_RPT_OUT   // wait for quotient and a free output register
    } t_state;

    t_state                     r_state;
    plsm_pkg::t_in_req          r_item;
    logic [TS_W-1:0]            r_thr;
    logic [plsm_pkg::INTV_W-1:0] r_intv;
    logic [1:0]                 r_grp_vld;
    logic [STG_DEPTH-1:0]       r_stg_vld;
    logic [SIDX_W-1:0]          r_sidx;
    logic [ADDR_W-1:0]          r_stg_addr;
    logic [CNT_W-1:0]           r_cnt;
    logic [TOT_W-1:0]           r_bytes;
    logic                       r_counted;
    logic [OSUM_W-1:0]          r_osum;
    plsm_pkg::t_stg_ent         r_ent;
    plsm_pkg::t_out_req         r_out;
    logic                       r_out_valid;

    plsm_pkg::t_grp_ent         w_grp_rdata;
    plsm_pkg::t_grp_ent         w_grp_cur;
    plsm_pkg::t_grp_ent         n_grp;
    logic                       w_grp_raddr;
    logic                       w_cnt_sat;
    logic [TOT_W:0]             w_bytes_sum;

    plsm_pkg::t_stg_ent         w_stg_rdata;
    plsm_pkg::t_stg_ent         w_stg_cur;
    plsm_pkg::t_stg_ent         n_ent;
    logic [ADDR_W-1:0]          w_stg_raddr;
    logic [ADDR_W-1:0]          w_base;
    logic [TS_W-1:0]            w_lat;
    logic [TOT_W:0]             w_tot_sum;
    logic [OSUM_W:0]            w_osum_sum;
    logic [OSUM_W-1:0]          n_osum;
    logic                       w_last;
    logic                       w_out_free;
    logic                       w_out_load;
    logic [TS_W-1:0]            w_avg;

    plsm_pkg::t_div_cmd         w_div_cmd;
    plsm_pkg::t_div_sts         w_div_sts;

    // stage latency; stages past the third carry zero
    function automatic logic [TS_W-1:0] lat_of(input plsm_pkg::t_in_req req,
                                               input int unsigned s);
        logic [TS_W-1:0] lat;
        case (s)
            0:       lat = req.bridge_recv_time - req.create_time;
            1:       lat = req.bridge_send_time - req.bridge_recv_time;
            2:       lat = req.api_recv_time - req.bridge_send_time;
            default: lat = '0;
        endcase
        return lat;
    endfunction

    // ---------------------------------------------------------------- memories
    // group RAM is read at accept time, so its data lines up with S_GRP
    assign w_grp_raddr = (r_state == S_IDLE) ? i_in.mode : r_item.mode;

    plsm_ram #(
        .WIDTH ($bits(plsm_pkg::t_grp_ent)),
        .DEPTH (2)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_GRP),
        .i_waddr (r_item.mode),
        .i_wdata (n_grp),
        .i_raddr (w_grp_raddr),
        .o_rdata (w_grp_rdata)
    );

    plsm_ram #(
        .WIDTH ($bits(plsm_pkg::t_stg_ent)),
        .DEPTH (STG_DEPTH)
    ) u_stg_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_STG),
        .i_waddr (r_stg_addr),
        .i_wdata (n_ent),
        .i_raddr (w_stg_raddr),
        .o_rdata (w_stg_rdata)
    );

    // base of this group's stage entries
    assign w_base = r_item.mode ? ADDR_W'(STAGES) : '0;

    // r_stg_addr always follows the address presented, so it names the data next cycle;
    // writing k while reading k+1 never touches the same entry
    always_comb begin
        case (r_state)
            S_GRP:    w_stg_raddr = w_base;
            S_STG:    w_stg_raddr = r_stg_addr + ADDR_W'(1);
            S_RPT_RD: w_stg_raddr = w_base + ADDR_W'(r_sidx);
            default:  w_stg_raddr = r_stg_addr;
        endcase
    end

    // ---------------------------------------------------------------- group update
    assign w_grp_cur   = r_grp_vld[r_item.mode] ? w_grp_rdata : '0;
    assign w_cnt_sat   = (w_grp_cur.packets == '1);
    assign w_bytes_sum = {1'b0, w_grp_cur.bytes} + (TOT_W + 1)'(r_item.packet_bytes);
    assign n_grp.packets = w_cnt_sat ? w_grp_cur.packets : w_grp_cur.packets + CNT_W'(1);
    assign n_grp.bytes   = w_bytes_sum[TOT_W] ? '1 : w_bytes_sum[TOT_W-1:0];

    // ---------------------------------------------------------------- stage update
    assign w_lat     = lat_of(r_item, 32'(r_sidx));
    assign w_last    = (r_sidx == SIDX_W'(STAGES - 1));
    assign w_stg_cur = r_stg_vld[r_stg_addr] ? w_stg_rdata : plsm_pkg::STG_ENT_RESET;
    assign w_tot_sum = {1'b0, w_stg_cur.total} + (TOT_W + 1)'(w_lat);

    assign n_ent.total = w_tot_sum[TOT_W] ? '1 : w_tot_sum[TOT_W-1:0];
    assign n_ent.overs = (w_lat > r_thr && w_stg_cur.overs != '1)
                       ? w_stg_cur.overs + OVR_W'(1) : w_stg_cur.overs;
    assign n_ent.lmax  = (w_lat > w_stg_cur.lmax) ? w_lat : w_stg_cur.lmax;
    assign n_ent.lmin  = (w_lat < w_stg_cur.lmin) ? w_lat : w_stg_cur.lmin;

    // running over-count sum, clamped at the 34-bit ceiling
    assign w_osum_sum = {1'b0, r_osum} + (OSUM_W + 1)'(n_ent.overs);
    assign n_osum     = w_osum_sum[OSUM_W] ? '1 : w_osum_sum[OSUM_W-1:0];

    // ---------------------------------------------------------------- divider
    // remainder check on the last stage update, averages on report
    always_comb begin
        w_div_cmd.short_op = (r_state == S_STG);
        w_div_cmd.start    = ((r_state == S_STG) && w_last && r_counted && (r_intv != '0))
                          || (r_state == S_RPT_DIV);
        w_div_cmd.dividend = (r_state == S_STG) ? plsm_pkg::DIV_N_W'(r_cnt)
                                                : w_stg_cur.total;
        w_div_cmd.divisor  = (r_state == S_STG) ? plsm_pkg::DIV_D_W'(r_intv) : r_cnt;
    end

    plsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_sts   (w_div_sts)
    );

    assign w_avg = (|w_div_sts.quotient[plsm_pkg::DIV_N_W-1:TS_W])
                 ? '1 : w_div_sts.quotient[TS_W-1:0];

    // ---------------------------------------------------------------- control
    assign w_out_free = !r_out_valid || !i_out_stall;
    // a result is loaded once its average is ready and the output register is free
    assign w_out_load = (r_state == S_RPT_OUT) && !w_div_sts.busy && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_grp_vld   <= '0;
            r_stg_vld   <= '0;
            r_sidx      <= '0;
            r_thr       <= plsm_pkg::THR_RESET;
            r_intv      <= plsm_pkg::INTV_RESET;
        end else begin
            r_stg_addr <= w_stg_raddr;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    plsm_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_wdata[TS_W-1:0];
                    plsm_pkg::CFG_INTERVAL:  r_intv <= i_cfg_wdata[plsm_pkg::INTV_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in;
                        r_state <= S_GRP;
                    end
                end
                S_GRP: begin
                    r_grp_vld[r_item.mode] <= 1'b1;
                    r_cnt     <= n_grp.packets;
                    r_bytes   <= n_grp.bytes;
                    r_counted <= !w_cnt_sat;
                    r_osum    <= '0;
                    r_sidx    <= '0;
                    r_state   <= S_STG;
                end
                S_STG: begin
                    r_stg_vld[r_stg_addr] <= 1'b1;
                    r_osum <= n_osum;
                    if (w_last) begin
                        r_state <= w_div_cmd.start ? S_MOD : S_IDLE;
                    end else begin
                        r_sidx <= r_sidx + SIDX_W'(1);
                    end
                end
                S_MOD: begin
                    if (!w_div_sts.busy) begin
                        if (w_div_sts.remainder == '0) begin
                            r_sidx  <= '0;
                            r_state <= S_RPT_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RPT_RD: begin
                    r_state <= S_RPT_DIV;
                end
                S_RPT_DIV: begin
                    r_ent   <= w_stg_cur;
                    r_state <= S_RPT_OUT;
                end
                S_RPT_OUT: begin
                    if (w_out_load) begin
                        r_out.group_id        <= r_item.mode;
                        r_out.stage           <= plsm_pkg::STAGE_W'(r_sidx);
                        r_out.packet_count    <= r_cnt;
                        r_out.byte_total      <= r_bytes;
                        r_out.latency_total   <= r_ent.total;
                        r_out.latency_average <= w_avg;
                        r_out.latency_max     <= r_ent.lmax;
                        r_out.latency_min     <= r_ent.lmin;
                        r_out.over_count      <= r_ent.overs;
                        r_out.over_sum        <= r_osum;
                        r_out.current_latency <= w_lat;
                        r_out.is_last         <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sidx  <= r_sidx + SIDX_W'(1);
                            r_state <= S_RPT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/plsm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for packet_latency_stats_monitor_core, bound to the top level.
// Depends on plsm_pkg.
module plsm_checker #(
    parameter int STAGES = plsm_pkg::STAGES_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input plsm_pkg::t_in_req               i_in,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input plsm_pkg::t_out_req              o_out,
    input logic                            i_cfg_we,
    input plsm_pkg::t_cfg_idx              i_cfg_idx,
    input logic [plsm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result request changed while stalled");

    // the final result of a report names the last stage
    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_last |-> o_out.stage == plsm_pkg::STAGE_W'(STAGES - 1))
        else $error("is_last on wrong stage");

    // while a report is still incomplete no new request is taken
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.is_last |-> o_in_stall)
        else $error("input taken in the middle of a report");

    // statistics of a reported stage are consistent
    a_stats_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.latency_min <= o_out.latency_max)
                     && (o_out.latency_average <= o_out.latency_max)
                     && (o_out.over_count <= o_out.packet_count))
        else $error("inconsistent stage statistics");

endmodule

bind packet_latency_stats_monitor_core plsm_checker #(.STAGES(STAGES)) u_plsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_wdata (i_cfg_wdata)
);
